// ===== rtl/core/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the six-axis window mean block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned NUM_AXES = 6;
  localparam int unsigned COUNT_W  = 4;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } swm_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clr;
    logic acc_en;
    logic div_load;
    logic div_step;
  } lane_ctrl_t;

endpackage

// ===== rtl/core/swm_lane.sv =====
// ----------------------------------------------------------------------------
// swm_lane
// One axis: sample store, serial accumulator and restoring divider.
// ----------------------------------------------------------------------------
module swm_lane #(
  parameter int unsigned WINDOW_DEPTH = 10,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                                 clk_i,
  input  swm_pkg::lane_ctrl_t                                  ctrl_i,
  input  logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] rd_addr_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                       sample_i,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]                    divisor_i,
  output logic signed [SAMPLE_WIDTH-1:0]                       mean_o
);
  import swm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_WIDTH + CNT_W;

  logic signed [SAMPLE_WIDTH-1:0] mem_q [WINDOW_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rd_data_q;
  logic signed [SUM_W-1:0]        acc_q;
  logic [SUM_W-1:0]               acc_mag;
  logic [SUM_W-1:0]               quo_q;
  logic [CNT_W-1:0]               rem_q;
  logic                           neg_q;
  logic [CNT_W:0]                 trial;
  logic [CNT_W:0]                 diff;
  logic                           ge;
  logic [CNT_W-1:0]               rem_d;
  logic [SAMPLE_WIDTH-1:0]        quo_lo;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= sample_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + SUM_W'(rd_data_q);
    end
  end

  assign acc_mag = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);

  // restoring division, one quotient bit per step
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = (trial >= {1'b0, divisor_i});
  assign rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      quo_q <= acc_mag;
      rem_q <= '0;
      neg_q <= acc_q[SUM_W-1];
    end else if (ctrl_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign quo_lo = quo_q[SAMPLE_WIDTH-1:0];
  assign mean_o = neg_q ? $signed(-quo_lo) : $signed(quo_lo);

endmodule

// ===== rtl/core/swm_merge.sv =====
// ----------------------------------------------------------------------------
// swm_merge
// Gathers the lane means and the count into the result register.
// ----------------------------------------------------------------------------
module swm_merge #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic                                clear_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      lane_mean_i [swm_pkg::NUM_AXES],
  input  logic [swm_pkg::COUNT_W-1:0]         count_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      mean_o [swm_pkg::NUM_AXES],
  output logic [swm_pkg::COUNT_W-1:0]         count_o
);
  import swm_pkg::*;

  logic                           valid_q;
  logic signed [SAMPLE_WIDTH-1:0] mean_q [NUM_AXES];
  logic [COUNT_W-1:0]             count_q;
  logic                           take;

  assign ready_o = !valid_q || out_ready_i;
  assign take    = load_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        mean_q[a] <= clear_i ? '0 : lane_mean_i[a];
      end
      count_q <= count_i;
    end
  end

  assign out_valid_o = valid_q;
  assign mean_o      = mean_q;
  assign count_o     = count_q;

endmodule

// ===== rtl/core/six_axis_window_mean.sv =====
// ----------------------------------------------------------------------------
// six_axis_window_mean
// Moving mean over the last WINDOW_DEPTH six-axis motion samples.
// ----------------------------------------------------------------------------
// One request is taken at a time. An add request writes the sample into six
// axis lanes, which then read back the stored samples one per cycle from
// their stores and divide the sum by the fill count one quotient bit per
// cycle, passing through the states ST_SUM, ST_DRAIN, ST_LOAD, ST_DIV and
// ST_DONE. A result waits in the output register while the next request is
// already being worked on.
module six_axis_window_mean #(
  parameter int unsigned WINDOW_DEPTH = 10,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] mean_gyro_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] mean_gyro_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] mean_gyro_z_o,
  output logic signed [SAMPLE_WIDTH-1:0] mean_accel_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] mean_accel_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] mean_accel_z_o,
  output logic [swm_pkg::COUNT_W-1:0]    sample_count_o
);
  import swm_pkg::*;

  localparam int unsigned ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_WIDTH + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  swm_state_e        state_q, state_d;
  lane_ctrl_t        ctrl;
  logic              in_acc;
  logic              done;
  logic              merge_ready;
  logic              sum_last;
  logic              div_last;
  logic [ADDR_W-1:0] wr_ptr_q;
  logic [CNT_W-1:0]  fill_q;
  logic [ADDR_W-1:0] rd_idx_q;
  logic              rd_vld_q;
  logic [STEP_W-1:0] step_q;
  logic              clr_q;

  logic signed [SAMPLE_WIDTH-1:0] axis_in   [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] lane_mean [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] out_mean  [NUM_AXES];

  assign axis_in[0] = gyro_x_i;
  assign axis_in[1] = gyro_y_i;
  assign axis_in[2] = gyro_z_i;
  assign axis_in[3] = accel_x_i;
  assign axis_in[4] = accel_y_i;
  assign axis_in[5] = accel_z_i;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign sum_last   = (CNT_W'(rd_idx_q) == fill_q - CNT_W'(1));
  assign div_last   = (step_q == STEP_W'(SUM_W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (operation_i == OP_CLEAR) ? ST_DONE : ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (merge_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.wr_en    = in_acc && (operation_i == OP_ADD);
    ctrl.acc_clr  = in_acc;
    ctrl.rd_en    = (state_q == ST_SUM);
    ctrl.acc_en   = rd_vld_q;
    ctrl.div_load = (state_q == ST_LOAD);
    ctrl.div_step = (state_q == ST_DIV);
    done          = (state_q == ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      step_q   <= '0;
      clr_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SUM);
      if (in_acc) begin
        clr_q    <= (operation_i == OP_CLEAR);
        rd_idx_q <= '0;
        if (operation_i == OP_CLEAR) begin
          wr_ptr_q <= '0;
          fill_q   <= '0;
        end else begin
          wr_ptr_q <= (wr_ptr_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
          if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
            fill_q <= fill_q + 1'b1;
          end
        end
      end else if (state_q == ST_SUM) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (state_q == ST_LOAD) begin
        step_q <= '0;
      end else if (state_q == ST_DIV) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    swm_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_addr_i (wr_ptr_q),
      .rd_addr_i (rd_idx_q),
      .sample_i  (axis_in[g]),
      .divisor_i (fill_q),
      .mean_o    (lane_mean[g])
    );
  end

  swm_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (done),
    .clear_i     (clr_q),
    .lane_mean_i (lane_mean),
    .count_i     (COUNT_W'(fill_q)),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mean_o      (out_mean),
    .count_o     (sample_count_o)
  );

  assign mean_gyro_x_o  = out_mean[0];
  assign mean_gyro_y_o  = out_mean[1];
  assign mean_gyro_z_o  = out_mean[2];
  assign mean_accel_x_o = out_mean[3];
  assign mean_accel_y_o = out_mean[4];
  assign mean_accel_z_o = out_mean[5];

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count above window depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(wr_ptr_q) < CNT_W'(WINDOW_DEPTH))
    else $error("write pointer outside store");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && operation_i == OP_CLEAR) |=> (fill_q == '0 && wr_ptr_q == '0))
    else $error("clear did not empty the window");

  a_sum_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (fill_q != '0))
    else $error("summing an empty window");

endmodule
